[sv/y2rgb_pkg.sv]
package y2rgb_pkg;

    // sample and arithmetic widths
    localparam int SAMPLE_W = 8;
    localparam int TERM_W   = 20;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 3;

    // bt.601 studio-range coefficients, 1/256 units
    localparam logic signed [TERM_W-1:0] K_LUMA    = 20'sd298;
    localparam logic signed [TERM_W-1:0] K_RED_CR  = 20'sd409;
    localparam logic signed [TERM_W-1:0] K_GRN_CB  = 20'sd100;
    localparam logic signed [TERM_W-1:0] K_GRN_CR  = 20'sd208;
    localparam logic signed [TERM_W-1:0] K_BLU_CB  = 20'sd516;
    localparam logic signed [TERM_W-1:0] K_ROUND   = 20'sd128;
    localparam logic signed [TERM_W-1:0] LUMA_OFS  = 20'sd16;
    localparam logic signed [TERM_W-1:0] CHROMA_OFS = 20'sd128;

    // output packing formats
    typedef enum logic [2:0] {
        FMT_RGB24      = 3'd0,
        FMT_BGR24      = 3'd1,
        FMT_RGB32      = 3'd2,
        FMT_BGR32      = 3'd3,
        FMT_RGB565     = 3'd4,
        FMT_RGB565_SWP = 3'd5
    } y2rgb_fmt_t;

    // byte counts per format
    localparam logic [COUNT_W-1:0] BYTES_16 = 3'd2;
    localparam logic [COUNT_W-1:0] BYTES_24 = 3'd3;
    localparam logic [COUNT_W-1:0] BYTES_32 = 3'd4;

    // register indexes on the config port
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_ALPHA  = 1'b1;

    // line and frame end marks travelling with each pixel
    typedef struct packed {
        logic line_end;
        logic frame_end;
    } y2rgb_marks_t;

    // floor divide by 256, then clamp to 0..255
    function automatic logic [SAMPLE_W-1:0] scale_clamp(input logic signed [TERM_W-1:0] sum);
        logic [SAMPLE_W-1:0] res;
        if (sum[TERM_W-1]) begin
            res = '0;
        end else if (|sum[TERM_W-2:16]) begin
            res = '1;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

endpackage

[sv/y2rgb_matrix.sv]
module y2rgb_matrix
    import y2rgb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] luma,
    input  logic [SAMPLE_W-1:0] chroma_blue,
    input  logic [SAMPLE_W-1:0] chroma_red,
    input  y2rgb_marks_t        in_marks,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] red,
    output logic [SAMPLE_W-1:0] green,
    output logic [SAMPLE_W-1:0] blue,
    output y2rgb_marks_t        out_marks
);

    // stage enables: a stage moves when empty or when the next one moves
    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // offset-removed samples
    logic signed [TERM_W-1:0] c_w, d_w, e_w;
    assign c_w = $signed({{(TERM_W-SAMPLE_W){1'b0}}, luma})        - LUMA_OFS;
    assign d_w = $signed({{(TERM_W-SAMPLE_W){1'b0}}, chroma_blue}) - CHROMA_OFS;
    assign e_w = $signed({{(TERM_W-SAMPLE_W){1'b0}}, chroma_red})  - CHROMA_OFS;

    // stage 1: coefficient products
    logic signed [TERM_W-1:0] y_reg, rv_reg, gu_reg, gv_reg, bu_reg;
    y2rgb_marks_t             m1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= in_valid;
        end
        if (en1) begin
            y_reg  <= c_w * K_LUMA;
            rv_reg <= e_w * K_RED_CR;
            gu_reg <= d_w * K_GRN_CB;
            gv_reg <= e_w * K_GRN_CR;
            bu_reg <= d_w * K_BLU_CB;
            m1_reg <= in_marks;
        end
    end

    // stage 2: channel sums with rounding term
    logic signed [TERM_W-1:0] r_sum_reg, g_sum_reg, b_sum_reg;
    y2rgb_marks_t             m2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
        if (en2) begin
            r_sum_reg <= y_reg + rv_reg + K_ROUND;
            g_sum_reg <= y_reg - gu_reg - gv_reg + K_ROUND;
            b_sum_reg <= y_reg + bu_reg + K_ROUND;
            m2_reg    <= m1_reg;
        end
    end

    // stage 3: scale and clamp
    logic [SAMPLE_W-1:0] r_reg, g_reg, b_reg;
    y2rgb_marks_t        m3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
        if (en3) begin
            r_reg  <= scale_clamp(r_sum_reg);
            g_reg  <= scale_clamp(g_sum_reg);
            b_reg  <= scale_clamp(b_sum_reg);
            m3_reg <= m2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;
    assign out_marks = m3_reg;

endmodule

[sv/yuv_to_rgb_multi_format_unit.sv]
// BT.601 studio-range YCbCr to RGB converter. Each input word carries one pixel's
// luma, Cb and Cr; the result word carries the packed pixel (first memory byte in
// bits 7..0) and its byte count, with line and frame end marks passed through.
// The block takes one pixel per clock while the output is not stalled; each pixel
// passes the product, sum and clamp registers and then the packing into the output
// register, which is the last stage. Select the packing through output_format
// (address 0x0: rgb24, bgr24, rgb32, bgr32, rgb565, rgb565 byte-swapped; codes 6
// and 7 pack as rgb24) and the fourth byte of the 32-bit formats through alpha_value
// (address 0x4). Change them only while no pixel is in flight.
module yuv_to_rgb_multi_format_unit
    import y2rgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
    input  logic        s_tlast,   // line_end
    input  logic        s_tuser,   // frame_end
    // output pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_word [31:0], byte_count [34:32], zero [39:35]
    output logic        m_tlast,   // line_end_out
    output logic        m_tuser    // frame_end_out
);

    // config registers
    logic [2:0]          format_reg;
    logic [SAMPLE_W-1:0] alpha_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FMT_RGB24;
            alpha_reg  <= '0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_FORMAT: format_reg <= pwdata[2:0];
                REG_ALPHA:  alpha_reg  <= pwdata[SAMPLE_W-1:0];
                default:    format_reg <= format_reg;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            REG_FORMAT: prdata = {29'd0, format_reg};
            REG_ALPHA:  prdata = {24'd0, alpha_reg};
            default:    prdata = '0;
        endcase
    end

    // colour matrix pipeline
    logic                mat_valid, mat_ready;
    logic [SAMPLE_W-1:0] r_w, g_w, b_w;
    y2rgb_marks_t        s_marks, mat_marks;

    assign s_marks.line_end  = s_tlast;
    assign s_marks.frame_end = s_tuser;

    y2rgb_matrix u_matrix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .luma        (s_tdata[7:0]),
        .chroma_blue (s_tdata[15:8]),
        .chroma_red  (s_tdata[23:16]),
        .in_marks    (s_marks),
        .out_valid   (mat_valid),
        .out_ready   (mat_ready),
        .red         (r_w),
        .green       (g_w),
        .blue        (b_w),
        .out_marks   (mat_marks)
    );

    // format packing
    logic [15:0]         p565_w;
    logic [WORD_W-1:0]   word_next;
    logic [COUNT_W-1:0]  count_next;

    assign p565_w = {r_w[7:3], g_w[7:2], b_w[7:3]};

    always_comb begin
        case (format_reg)
            FMT_BGR24: begin
                word_next  = {8'd0, r_w, g_w, b_w};
                count_next = BYTES_24;
            end
            FMT_RGB32: begin
                word_next  = {alpha_reg, b_w, g_w, r_w};
                count_next = BYTES_32;
            end
            FMT_BGR32: begin
                word_next  = {alpha_reg, r_w, g_w, b_w};
                count_next = BYTES_32;
            end
            FMT_RGB565: begin
                word_next  = {16'd0, p565_w};
                count_next = BYTES_16;
            end
            FMT_RGB565_SWP: begin
                word_next  = {16'd0, p565_w[7:0], p565_w[15:8]};
                count_next = BYTES_16;
            end
            default: begin
                word_next  = {8'd0, b_w, g_w, r_w};
                count_next = BYTES_24;
            end
        endcase
    end

    // output register
    logic               out_valid_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [COUNT_W-1:0] count_reg;
    y2rgb_marks_t       marks_reg;

    assign mat_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mat_ready) begin
            out_valid_reg <= mat_valid;
        end
        if (mat_ready) begin
            word_reg  <= word_next;
            count_reg <= count_next;
            marks_reg <= mat_marks;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, count_reg, word_reg};
    assign m_tlast  = marks_reg.line_end;
    assign m_tuser  = marks_reg.frame_end;

    // checks
    a_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count_reg == BYTES_16 || count_reg == BYTES_24 ||
                      count_reg == BYTES_32))
        else $error("byte count out of range");

    a_pad_24: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && count_reg == BYTES_24) |-> (word_reg[31:24] == 8'd0))
        else $error("unused top byte not zero");

    a_pad_16: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && count_reg == BYTES_16) |-> (word_reg[31:16] == 16'd0))
        else $error("unused upper bytes not zero");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // first cycle out of reset
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("output valid after reset");

endmodule
